/* hw/rtl/bcn_pkg.sv */
package bcn_pkg;

  // payload store geometry
  localparam int MAX_PAYLOAD = 128;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W       = $clog2(MAX_PAYLOAD + 7);

  // frame layout: 5 header bytes, payload, 1 trailer byte
  localparam int HDR_LEN     = 5;
  localparam int FRAME_EXTRA = 6;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] SFD_BYTE  = 8'hD5;
  localparam logic [7:0] STX_BYTE  = 8'h02;
  localparam logic [7:0] ETX_BYTE  = 8'h03;

  // timing
  localparam int TICK_W          = 24;
  localparam int SLOT_W          = 13;
  localparam int HALF_W          = 5;
  localparam int SENT_W          = 20;
  localparam int HALVES_PER_BYTE = 20;
  localparam int LEAD_MULT       = 30;
  localparam int GAP_MULT        = 10;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT   = 1'b1;
  localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = 24'd4000;
  localparam logic [SENT_W-1:0] PACKET_LIMIT_RST   = 20'd100000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    PH_LOADING = 5'b00001,
    PH_LEAD    = 5'b00010,
    PH_SEND    = 5'b00100,
    PH_GAP     = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              line_level;
    logic              sending;
    logic              finished;
    logic [SENT_W-1:0] packets_done;
  } result_t;

endpackage

/* hw/rtl/bcn_ram.sv */
module bcn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/bcn_core.sv */
module bcn_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [1:0]                    op,
  input  logic [7:0]                    data_byte,
  input  logic                          cfg_wen,
  input  logic [bcn_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [bcn_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bcn_pkg::result_t              result
);
  import bcn_pkg::*;

  // configuration
  logic [TICK_W-1:0] half_bit_ticks;
  logic [SENT_W-1:0] packet_limit;

  // state
  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  payload_count, payload_count_next;
  logic [TICK_W-1:0] tick_in_slot, tick_in_slot_next;
  logic [SLOT_W-1:0] slot_count, slot_count_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [HALF_W-1:0] half_position, half_position_next;
  logic [SENT_W-1:0] sent_count, sent_count_next;
  logic              level_reg, level_reg_next;
  logic [7:0]        cur_byte, cur_byte_next;

  // store
  logic              wr_en;
  logic [PAY_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  // datapath
  logic [TICK_W-1:0] tick_inc, h_eff;
  logic              slot_end;
  logic [POS_W-1:0]  frame_len, nb_pos;
  logic [SLOT_W-1:0] wait_slots, slot_inc;
  logic [HALF_W-1:0] half_inc;
  logic [SENT_W-1:0] sent_inc;
  logic [7:0]        next_byte;

  function automatic logic half_level(input logic [7:0] value, input logic [HALF_W-1:0] half);
    logic [HALF_W-1:0] rel;
    logic              b;
    rel = half - HALF_W'(2);
    b   = value[rel[3:1]];
    if (half == HALF_W'(0))                    return 1'b1;
    else if (half == HALF_W'(1))               return 1'b0;
    else if (half == HALF_W'(HALVES_PER_BYTE - 2)) return 1'b0;
    else if (half >= HALF_W'(HALVES_PER_BYTE - 1)) return 1'b1;
    else if (!half[0])                         return ~b;
    else                                       return b;
  endfunction

  // the store is read at the address of the payload byte that follows the current one
  assign rd_addr = PAY_AW'(byte_position - POS_W'(HDR_LEN - 1));

  bcn_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (PAY_AW'(payload_count)),
    .wr_data (data_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    tick_inc   = tick_in_slot + TICK_W'(1);
    h_eff      = (half_bit_ticks == '0) ? TICK_W'(1) : half_bit_ticks;
    slot_end   = (tick_inc >= h_eff);
    frame_len  = POS_W'(payload_count) + POS_W'(FRAME_EXTRA);
    wait_slots = (phase == PH_LEAD) ? SLOT_W'(LEAD_MULT) * SLOT_W'(frame_len)
                                    : SLOT_W'(GAP_MULT) * SLOT_W'(frame_len);
    slot_inc   = slot_count + SLOT_W'(1);
    half_inc   = half_position + HALF_W'(1);
    sent_inc   = sent_count + SENT_W'(1);
    nb_pos     = byte_position + POS_W'(1);

    if (nb_pos < POS_W'(3))                         next_byte = SYNC_BYTE;
    else if (nb_pos == POS_W'(3))                   next_byte = SFD_BYTE;
    else if (nb_pos == POS_W'(4))                   next_byte = STX_BYTE;
    else if (nb_pos + POS_W'(1) >= frame_len)       next_byte = ETX_BYTE;
    else                                            next_byte = rd_data;

    phase_next         = phase;
    payload_count_next = payload_count;
    tick_in_slot_next  = tick_in_slot;
    slot_count_next    = slot_count;
    byte_position_next = byte_position;
    half_position_next = half_position;
    sent_count_next    = sent_count;
    level_reg_next     = level_reg;
    cur_byte_next      = cur_byte;
    wr_en              = 1'b0;

    if (step) begin
      case (op_t'(op))
        OP_LOAD: begin
          if (phase == PH_LOADING && payload_count < CNT_W'(MAX_PAYLOAD)) begin
            wr_en              = 1'b1;
            payload_count_next = payload_count + CNT_W'(1);
          end
        end
        OP_START: begin
          if (phase == PH_LOADING) begin
            phase_next        = PH_LEAD;
            tick_in_slot_next = '0;
            slot_count_next   = '0;
          end
        end
        OP_TICK: begin
          case (phase)
            PH_LEAD, PH_GAP: begin
              tick_in_slot_next = slot_end ? '0 : tick_inc;
              if (slot_end) begin
                slot_count_next = slot_inc;
                if (slot_inc >= wait_slots) begin
                  slot_count_next    = '0;
                  byte_position_next = '0;
                  half_position_next = '0;
                  phase_next         = PH_SEND;
                  level_reg_next     = 1'b1;
                  cur_byte_next      = SYNC_BYTE;
                end
              end
            end
            PH_SEND: begin
              tick_in_slot_next = slot_end ? '0 : tick_inc;
              if (slot_end) begin
                if (half_inc >= HALF_W'(HALVES_PER_BYTE)) begin
                  half_position_next = '0;
                  if (nb_pos >= frame_len) begin
                    // last half-bit of trailer done: packet complete
                    byte_position_next = '0;
                    sent_count_next    = sent_inc;
                    slot_count_next    = '0;
                    phase_next         = (sent_inc >= packet_limit) ? PH_DONE : PH_GAP;
                  end else begin
                    byte_position_next = nb_pos;
                    cur_byte_next      = next_byte;
                    level_reg_next     = 1'b1;
                  end
                end else begin
                  half_position_next = half_inc;
                  level_reg_next     = half_level(cur_byte, half_inc);
                end
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end

    result.line_level   = level_reg_next;
    result.sending      = (phase_next == PH_SEND);
    result.finished     = (phase_next == PH_DONE);
    result.packets_done = sent_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks <= HALF_BIT_TICKS_RST;
      packet_limit   <= PACKET_LIMIT_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_HALF_BIT_TICKS: half_bit_ticks <= cfg_wdata[TICK_W-1:0];
        CFG_PACKET_LIMIT:   packet_limit   <= cfg_wdata[SENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LOADING;
      payload_count <= '0;
      tick_in_slot  <= '0;
      slot_count    <= '0;
      byte_position <= '0;
      half_position <= '0;
      sent_count    <= '0;
      level_reg     <= 1'b0;
    end else begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      tick_in_slot  <= tick_in_slot_next;
      slot_count    <= slot_count_next;
      byte_position <= byte_position_next;
      half_position <= half_position_next;
      sent_count    <= sent_count_next;
      level_reg     <= level_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte <= cur_byte_next;
  end

  a_send_pos: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SEND |-> half_position < HALF_W'(HALVES_PER_BYTE) && byte_position < frame_len)
    else $error("send position out of frame");

  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_GAP || phase == PH_DONE) |-> level_reg)
    else $error("line not held high after packet");

  a_sent_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(sent_count) |-> $past(phase) == PH_SEND && sent_count == $past(sent_count) + SENT_W'(1))
    else $error("packet count moved outside a packet end");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |=> phase == PH_DONE && $stable(level_reg))
    else $error("left finished state");

endmodule

/* hw/rtl/framed_manchester_beacon_tx.sv */
// Periodic Manchester beacon transmitter.
//
// Input stream (s_*): each transaction carries a command in s_tuser
// (0 load payload byte, 1 start, 2 time tick) and the payload byte in
// s_tdata. Load bytes first (up to 128; extra loads are dropped), then
// start. Ticks then drive the schedule: a lead wait of 30*L half-bits,
// packets of L bytes (AA AA AA D5 02, payload, 03) at 20 half-bits per
// byte, and gaps of 10*L half-bits, until packet_limit packets are sent.
//
// Output stream (m_*): exactly one result transaction per input
// transaction, showing the line state after that command. The result is
// registered; throughput is one transaction per cycle while m_tready is
// high. The state update is one pass of counter logic; the next payload
// byte is prefetched from the store's registered read port.
//
// Config port: cfg_wen writes cfg_wdata into register cfg_addr
// (0 half_bit_ticks, 1 packet_limit); write only while idle.
// Reset clears all control state and restores the register defaults
// (4000 and 100000); the store needs no clearing. When m_tready is low,
// s_tready drops once the result register holds an untaken result.
module framed_manchester_beacon_tx (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic [1:0]                     s_tuser,   // [1:0] op
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] line_level, [1] sending, [2] finished, [22:3] packets_done, [23] zero
  output logic [23:0]                    m_tdata,
  input  logic                           cfg_wen,
  input  logic [bcn_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [bcn_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bcn_pkg::*;

  logic    accept;
  result_t result;

  // the result register frees up in the same cycle it is drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  bcn_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .op        (s_tuser),
    .data_byte (s_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, result.packets_done, result.finished, result.sending,
                  result.line_level};
    end
  end

endmodule

/* tb/sv/framed_manchester_beacon_tx_tb.sv */
`timescale 1ns / 1ps

module framed_manchester_beacon_tx_tb;
  import bcn_pkg::*;

  // op code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam result_t    ZERO_STATUS = '0;
  localparam int         SCRIPT_LEN = 12;
  // the payload is loaded right before this script row (the first start)
  localparam int         LOAD_AT = 4;

  typedef enum int {PAY_EMPTY, PAY_SHORT} pay_mode_t;

  // one row of the directed script; want is used only when typed is set
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  framed_manchester_beacon_tx dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Beacon predictor: own copy of the transmitter state and its registers
  // ---------------------------------------------------------------------------
  logic [7:0]  pay_mem [MAX_PAYLOAD];
  int unsigned pay_cnt;
  phase_t      tx_phase;
  logic [23:0] slot_ticks;    // ticks counted in the current half-bit slot
  logic [12:0] slot_idx;      // slots counted in a lead or gap wait
  int unsigned byte_idx;
  int unsigned half_idx;
  logic [19:0] pkts_sent;
  logic        line_q;
  logic [23:0] half_ticks_cfg;
  logic [19:0] limit_cfg;

  // status of the line after each accepted command, oldest first
  result_t     awaited_status [$];
  int unsigned fail_count = 0;
  pay_mode_t   payload_mode;

  function automatic void beacon_reset();
    pay_cnt        = 0;
    tx_phase       = PH_LOADING;
    slot_ticks     = '0;
    slot_idx       = '0;
    byte_idx       = 0;
    half_idx       = 0;
    pkts_sent      = '0;
    line_q         = 1'b0;
    half_ticks_cfg = HALF_BIT_TICKS_RST;
    limit_cfg      = PACKET_LIMIT_RST;
  endfunction

  // byte at position pos of the frame: sync x3, SFD, STX, payload, ETX
  function automatic logic [7:0] frame_octet(int unsigned pos);
    if (pos < 3) return SYNC_BYTE;
    if (pos == 3) return SFD_BYTE;
    if (pos == HDR_LEN - 1) return STX_BYTE;
    if (pos + 1 >= pay_cnt + FRAME_EXTRA) return ETX_BYTE;
    return pay_mem[pos - HDR_LEN];
  endfunction

  // line level of half-bit h of a byte: start pair, LSB-first bits, end pair
  function automatic logic manch_level(logic [7:0] b, int unsigned h);
    logic bitv;
    if (h == 0) return 1'b1;
    if (h == 1) return 1'b0;
    if (h == 18) return 1'b0;
    if (h >= 19) return 1'b1;
    bitv = b[(h - 2) / 2];
    return (h % 2 == 0) ? ~bitv : bitv;
  endfunction

  // one tick of the slot timer; a zero setting counts as one
  function automatic bit slot_done();
    logic [23:0] lim;
    lim = (half_ticks_cfg == '0) ? 24'd1 : half_ticks_cfg;
    slot_ticks = slot_ticks + 24'd1;
    if (slot_ticks >= lim) begin
      slot_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void wait_slot(int unsigned slots);
    if (!slot_done()) return;
    slot_idx = slot_idx + 13'd1;
    if (32'(slot_idx) >= slots) begin
      slot_idx = '0;
      byte_idx = 0;
      half_idx = 0;
      tx_phase = PH_SEND;
      line_q   = manch_level(frame_octet(0), 0);
    end
  endfunction

  function automatic void send_slot();
    if (!slot_done()) return;
    half_idx++;
    if (half_idx >= HALVES_PER_BYTE) begin
      half_idx = 0;
      byte_idx++;
      if (byte_idx >= pay_cnt + FRAME_EXTRA) begin
        // packet complete: line holds its last level
        byte_idx  = 0;
        pkts_sent = pkts_sent + 20'd1;
        slot_idx  = '0;
        tx_phase  = (pkts_sent >= limit_cfg) ? PH_DONE : PH_GAP;
        return;
      end
    end
    line_q = manch_level(frame_octet(byte_idx), half_idx);
  endfunction

  function automatic result_t beacon_step(logic [1:0] op, logic [7:0] data);
    result_t r;
    case (op)
      OP_LOAD: begin
        if (tx_phase == PH_LOADING && pay_cnt < MAX_PAYLOAD) begin
          pay_mem[pay_cnt] = data;
          pay_cnt++;
        end
      end
      OP_START: begin
        if (tx_phase == PH_LOADING) begin
          tx_phase   = PH_LEAD;
          slot_ticks = '0;
          slot_idx   = '0;
        end
      end
      OP_TICK: begin
        case (tx_phase)
          PH_LEAD: wait_slot(LEAD_MULT * (pay_cnt + FRAME_EXTRA));
          PH_GAP:  wait_slot(GAP_MULT * (pay_cnt + FRAME_EXTRA));
          PH_SEND: send_slot();
          default: ;
        endcase
      end
      default: ;
    endcase
    r.line_level   = line_q;
    r.sending      = (tx_phase == PH_SEND);
    r.finished     = (tx_phase == PH_DONE);
    r.packets_done = pkts_sent;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly short, a few long; calm stretches have none at all
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 3);
  endfunction

  int unsigned src_left = 0;
  bit          src_calm = 1'b0;
  int unsigned sink_left = 0;
  int unsigned sink_stall = 0;
  bit          sink_calm = 1'b0;

  // result side backpressure, changed on the falling edge
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_calm = ($urandom_range(0, 3) == 0);
      sink_left = $urandom_range(20, 150);
    end
    sink_left--;
    if (sink_stall > 0) begin
      m_tready = 1'b0;
      sink_stall--;
    end else begin
      m_tready = 1'b1;
      if (!sink_calm && $urandom_range(0, 3) == 0) sink_stall = idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every output transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  result_t want_st;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_status.size() == 0) begin
        $display("%0t ns: unexpected result transaction, expected none, actual %h",
                 $time, m_tdata);
        fail_count++;
      end else begin
        want_st = awaited_status.pop_front();
        check_field("line_level", want_st.line_level, m_tdata[0]);
        check_field("sending", want_st.sending, m_tdata[1]);
        check_field("finished", want_st.finished, m_tdata[2]);
        check_field("packets_done", want_st.packets_done, m_tdata[22:3]);
        check_field("pad bit", 0, m_tdata[23]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver; all tasks below start and end on a falling edge
  // ---------------------------------------------------------------------------
  task automatic issue_cmd(logic [1:0] op, logic [7:0] data, logic typed, result_t want);
    result_t     got_pred;
    int unsigned gap;
    if (src_left == 0) begin
      src_calm = ($urandom_range(0, 3) == 0);
      src_left = $urandom_range(20, 120);
    end
    src_left--;
    gap = (!src_calm && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = data;
    do @(posedge clk); while (!s_tready);
    // transaction taken at this edge: predict its status
    got_pred = beacon_step(op, data);
    awaited_status.push_back(typed ? want : got_pred);
    @(negedge clk);
  endtask

  // hold off the sender until every expected status has come back
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (awaited_status.size() != 0) @(negedge clk);
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_wen   = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    if (idx == CFG_HALF_BIT_TICKS) half_ticks_cfg = val[23:0];
    else limit_cfg = val[19:0];
  endtask

  task automatic write_limit(logic [19:0] lim);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));  // bits above the register width are dropped
    write_reg(CFG_PACKET_LIMIT, {junk, lim});
  endtask

  // mostly ticks; loads, starts and the unused op are noise once started
  task automatic run_mix(int unsigned n);
    int unsigned r;
    logic [1:0]  op;
    repeat (n) begin
      r  = $urandom_range(0, 99);
      op = (r < 88) ? OP_TICK : (r < 93) ? OP_LOAD : (r < 97) ? OP_START : OP_UNUSED;
      if ($urandom_range(0, 149) == 0) wait_drained();
      issue_cmd(op, 8'($urandom_range(0, 255)), 1'b0, ZERO_STATUS);
    end
  endtask

  // new half-bit setting between runs of ticks; returns the run length
  task automatic retune(output int unsigned chunk);
    int unsigned r;
    r = $urandom_range(0, 9);
    chunk = $urandom_range(60, 180);
    if (r == 0) begin
      // top setting: slots stall, the next lower setting cuts the slot short
      write_reg(CFG_HALF_BIT_TICKS, 24'hFF_FFFF);
      chunk = $urandom_range(20, 60);
    end else if (r == 1) write_reg(CFG_HALF_BIT_TICKS, 24'd0);
    else if (r == 2) write_reg(CFG_HALF_BIT_TICKS, 24'(r));
    else if (r == 3) write_reg(CFG_HALF_BIT_TICKS, 24'($urandom_range(1, 3)));
    else write_reg(CFG_HALF_BIT_TICKS, 24'd1);
  endtask

  task automatic load_payload();
    int unsigned count;
    logic [7:0]  b;
    case (payload_mode)
      PAY_EMPTY: count = 0;
      default:   count = $urandom_range(1, 4);
    endcase
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0)
        issue_cmd(($urandom_range(0, 1) != 0) ? OP_TICK : OP_UNUSED,
                  8'($urandom_range(0, 255)), 1'b0, ZERO_STATUS);
      b = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      issue_cmd(OP_LOAD, b, 1'b0, ZERO_STATUS);
    end
  endtask

  // directed script; before start and in the lead wait every output is zero
  script_row_t script [SCRIPT_LEN];

  initial begin
    int unsigned chunk;
    int unsigned r;
    logic [19:0] lim;

    script[0]  = '{OP_TICK,   8'h00, 1'b1, ZERO_STATUS};  // tick before start
    script[1]  = '{OP_TICK,   8'hFF, 1'b1, ZERO_STATUS};
    script[2]  = '{OP_UNUSED, 8'h00, 1'b1, ZERO_STATUS};  // unused op code
    script[3]  = '{OP_UNUSED, 8'hFF, 1'b1, ZERO_STATUS};
    script[4]  = '{OP_START,  8'h5A, 1'b1, ZERO_STATUS};
    script[5]  = '{OP_START,  8'hA5, 1'b1, ZERO_STATUS};  // second start ignored
    script[6]  = '{OP_LOAD,   8'hFF, 1'b1, ZERO_STATUS};  // load after start ignored
    script[7]  = '{OP_UNUSED, 8'h3C, 1'b1, ZERO_STATUS};
    script[8]  = '{OP_TICK,   8'h00, 1'b0, ZERO_STATUS};
    script[9]  = '{OP_TICK,   8'hFF, 1'b0, ZERO_STATUS};
    script[10] = '{OP_TICK,   8'h81, 1'b0, ZERO_STATUS};
    script[11] = '{OP_LOAD,   8'h00, 1'b0, ZERO_STATUS};

    // mostly short payloads, sometimes none at all
    r = $urandom_range(0, 7);
    payload_mode = (r < 2) ? PAY_EMPTY : PAY_SHORT;

    beacon_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // extremes first: ticks in the lead wait pile up inside one slot
    write_reg(CFG_HALF_BIT_TICKS, 24'hFF_FFFF);
    write_limit(20'hF_FFFF);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (i == LOAD_AT) load_payload();
      issue_cmd(script[i].op, script[i].data, script[i].typed, script[i].want);
    end

    // zero acts as one; the long open slot closes on the next tick
    wait_drained();
    write_reg(CFG_HALF_BIT_TICKS, 24'd0);
    chunk = $urandom_range(60, 180);

    while (pkts_sent < 20'd1) begin
      run_mix(chunk);
      wait_drained();
      retune(chunk);
    end

    // limit lowered to or below the count, or just above it; only looked at
    // when a packet completes
    case ($urandom_range(0, 3))
      0:       lim = 20'd0;
      1:       lim = 20'd1;
      2:       lim = pkts_sent + 20'd1;
      default: lim = pkts_sent + 20'd2;
    endcase
    write_limit(lim);

    while (tx_phase != PH_DONE) begin
      run_mix(chunk);
      wait_drained();
      retune(chunk);
    end

    // finished: ticks and late writes change nothing
    write_limit(20'hF_FFFF);
    run_mix($urandom_range(40, 80));

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("framed_manchester_beacon_tx_tb: PASS");
    end else begin
      $display("framed_manchester_beacon_tx_tb: FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("framed_manchester_beacon_tx_tb: FAIL");
    $finish;
  end

endmodule
